### design/lcbb_pkg.sv
// Shared constants, types and helpers of the light cone bounding box.
package lcbb_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int PH_W       = 32;
  localparam int Q_BITS     = 33;
  localparam int N_STEP     = 5;
  localparam int STEP_LAT   = 3;
  localparam int X_DLY      = N_STEP * STEP_LAT + 1;
  localparam int O_DLY      = X_DLY + 1;
  localparam int TRIG_LAT   = X_DLY + 3;
  localparam int DIV_LAT    = Q_BITS + 3;
  localparam int BOX_LAT    = 4;
  localparam int CORE_LAT   = TRIG_LAT + DIV_LAT;
  localparam int Q_DEPTH    = 4;
  localparam int QP_W       = 2;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  // cosine series divisors and floor(2^32 / d)
  localparam logic [6:0]  COS_DIV [N_STEP] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] COS_RECIP [N_STEP] = '{
    32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};
  // sine series
  localparam logic [6:0]  SIN_DIV [N_STEP-1] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] SIN_RECIP [N_STEP-1] = '{
    32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
    logic               special;
    logic [PH_W-1:0]    ph_h;
    logic [PH_W-1:0]    ph_1;
    logic [PH_W-1:0]    ph_2;
  } entry_t;

  function automatic logic signed [35:0] min3(input logic signed [35:0] a,
                                              input logic signed [35:0] b,
                                              input logic signed [35:0] c);
    logic signed [35:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [35:0] max3(input logic signed [35:0] a,
                                              input logic signed [35:0] b,
                                              input logic signed [35:0] c);
    logic signed [35:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/lcbb_front.sv
// Front end: accepts an item, sorts out the plain-box case and builds the phases.
module lcbb_front import lcbb_pkg::*; (
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        light_radius,
  input  logic [15:0]        direction_angle,
  input  logic [16:0]        spread_angle,
  output logic               wr,
  output entry_t             ent
);

  logic [PH_W-1:0] dph;
  logic [PH_W-1:0] hph;

  // the direction fills the phase word exactly and the spread is halved; ph_1 and ph_2 wrap
  assign dph = PH_W'(direction_angle) << (PH_W - ANGLE_BITS);
  assign hph = PH_W'(spread_angle) << (PH_W - 1 - ANGLE_BITS);

  assign wr          = push && !full;
  assign ent.cx      = center_x;
  assign ent.cy      = center_y;
  assign ent.rad     = light_radius;
  assign ent.special = (spread_angle == '0) ||
                       (spread_angle >= 17'(1 << ANGLE_BITS));
  assign ent.ph_h    = hph;
  assign ent.ph_1    = dph + hph;
  assign ent.ph_2    = dph - hph;

endmodule

### design/lcbb_queue.sv
// Short queue between the front end and the compute pipeline.
module lcbb_queue import lcbb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_ent,
  input  logic   rd,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t          slots [Q_DEPTH];
  logic [QP_W-1:0] wp;
  logic [QP_W-1:0] rp;
  logic [QP_W:0]   cnt;

  assign full  = (cnt == (QP_W+1)'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### design/lcbb_hstep.sv
// One Horner step of the sine/cosine series: t = 1 - ((x2 * t) >> 30) / d.
module lcbb_hstep import lcbb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] x2_i,
  input  logic [30:0] t_i,
  input  logic [31:0] recip,
  input  logic [6:0]  dvsr,
  output logic [29:0] x2_o,
  output logic [30:0] t_o
);

  logic [60:0] p1;
  logic [61:0] p2;
  logic [29:0] x2a;
  logic [29:0] x2b;
  logic [29:0] v;
  logic [29:0] vb;
  logic [29:0] q0;
  logic [29:0] qd;
  logic [29:0] rr;
  logic [30:0] qq;

  assign v  = p1[59:30];
  assign q0 = p2[61:32];
  // reciprocal estimate is low by at most one
  assign qd = q0 * 30'(dvsr);
  assign rr = vb - qd;
  assign qq = {1'b0, q0} + 31'(rr >= 30'(dvsr));

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= 61'(x2_i) * 61'(t_i);
      x2a  <= x2_i;
      p2   <= 62'(v) * 62'(recip);
      vb   <= v;
      x2b  <= x2a;
      t_o  <= ONE_Q30 - qq;
      x2_o <= x2b;
    end
  end

endmodule

### design/lcbb_trig.sv
// Pipelined sine and cosine of a 32-bit phase, Q2.30 results.
module lcbb_trig import lcbb_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [PH_W-1:0]    phase,
  output logic signed [31:0] cs_o,
  output logic signed [31:0] sn_o
);

  logic [2:0]  oct;
  logic [29:0] m;
  logic [29:0] xa;
  logic [2:0]  oa;
  logic [29:0] x2r;
  logic [29:0] x_d [X_DLY];
  logic [2:0]  o_d [O_DLY];
  logic [29:0] cx2 [N_STEP+1];
  logic [30:0] ct  [N_STEP+1];
  logic [29:0] sx2 [N_STEP];
  logic [30:0] stt [N_STEP];
  logic [30:0] s_r;
  logic [30:0] c_r;
  logic signed [31:0] sv;
  logic signed [31:0] cv;
  logic signed [31:0] st_v;
  logic signed [31:0] ct_v;
  logic [2:0]  o_end;

  assign oct = phase[31:29];
  assign m   = oct[0] ? (30'(1 << 29) - 30'(phase[28:0])) : 30'(phase[28:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      xa     <= 30'((62'(m) * 62'(PI_Q30)) >> 31);
      oa     <= oct;
      x2r    <= 30'((60'(xa) * 60'(xa)) >> 30);
      x_d[0] <= xa;
      o_d[0] <= oa;
      for (int k = 1; k < X_DLY; k++) begin
        x_d[k] <= x_d[k-1];
      end
      for (int k = 1; k < O_DLY; k++) begin
        o_d[k] <= o_d[k-1];
      end
    end
  end

  assign cx2[0] = x2r;
  assign ct[0]  = ONE_Q30;

  for (genvar k = 0; k < N_STEP; k++) begin : g_cos
    lcbb_hstep u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (cx2[k]),
      .t_i  (ct[k]),
      .recip(COS_RECIP[k]),
      .dvsr (COS_DIV[k]),
      .x2_o (cx2[k+1]),
      .t_o  (ct[k+1])
    );
  end

  // sine chain is one step shorter; it starts one step later
  assign sx2[0] = cx2[1];
  assign stt[0] = ONE_Q30;

  for (genvar k = 0; k < N_STEP-1; k++) begin : g_sin
    lcbb_hstep u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (sx2[k]),
      .t_i  (stt[k]),
      .recip(SIN_RECIP[k]),
      .dvsr (SIN_DIV[k]),
      .x2_o (sx2[k+1]),
      .t_o  (stt[k+1])
    );
  end

  assign o_end = o_d[O_DLY-1];
  assign sv    = signed'({1'b0, s_r});
  assign cv    = signed'({1'b0, c_r});
  assign st_v  = o_end[0] ? cv : sv;
  assign ct_v  = o_end[0] ? sv : cv;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= 31'((61'(x_d[X_DLY-1]) * 61'(stt[N_STEP-1])) >> 30);
      c_r <= ct[N_STEP];
      case (o_end[2:1])
        2'd0: begin
          cs_o <= ct_v;
          sn_o <= st_v;
        end
        2'd1: begin
          cs_o <= -st_v;
          sn_o <= ct_v;
        end
        2'd2: begin
          cs_o <= -ct_v;
          sn_o <= -st_v;
        end
        default: begin
          cs_o <= st_v;
          sn_o <= -ct_v;
        end
      endcase
    end
  end

endmodule

### design/lcbb_div.sv
// Pipelined radius * trig / den, one quotient bit per stage, capped at 2^Q_BITS.
module lcbb_div import lcbb_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [30:0]              radius,
  input  logic signed [31:0]       trig,
  input  logic [30:0]              den,
  output logic signed [Q_BITS+1:0] q_o
);

  logic [31:0]       mag;
  logic [60:0]       prod;
  logic              neg1;
  logic              zero1;
  logic [30:0]       den1;
  logic [60:0]       rem   [Q_BITS+1];
  logic [Q_BITS-1:0] quo   [Q_BITS+1];
  logic [30:0]       den_s [Q_BITS+1];
  logic              big_s [Q_BITS+1];
  logic              neg_s [Q_BITS+1];
  logic              zer_s [Q_BITS+1];
  logic [Q_BITS:0]   mq;

  assign mag = trig[31] ? 32'(-trig) : 32'(trig);

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= 61'(radius) * 61'(mag[30:0]);
      neg1     <= trig[31];
      zero1    <= (mag == '0) || (radius == '0);
      den1     <= den;
      // quotient of 2^Q_BITS or more lands outside any bound anyway
      big_s[0] <= (den1 == '0) || ({3'b0, prod} >= (64'(den1) << Q_BITS));
      rem[0]   <= prod;
      quo[0]   <= '0;
      den_s[0] <= den1;
      neg_s[0] <= neg1;
      zer_s[0] <= zero1;
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
    logic [63:0] dsh;
    logic        ge;
    assign dsh = 64'(den_s[k]) << (Q_BITS - 1 - k);
    assign ge  = {3'b0, rem[k]} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        den_s[k+1] <= den_s[k];
        big_s[k+1] <= big_s[k];
        neg_s[k+1] <= neg_s[k];
        zer_s[k+1] <= zer_s[k];
        if (ge) begin
          rem[k+1] <= rem[k] - 61'(dsh);
          quo[k+1] <= quo[k] | (Q_BITS'(1) << (Q_BITS - 1 - k));
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  always_comb begin
    if (zer_s[Q_BITS]) begin
      mq = '0;
    end else if (big_s[Q_BITS]) begin
      mq = (Q_BITS+1)'(1) << Q_BITS;
    end else begin
      mq = {1'b0, quo[Q_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o <= neg_s[Q_BITS] ? -signed'({1'b0, mq}) : signed'({1'b0, mq});
    end
  end

endmodule

### design/lcbb_back.sv
// Back end: trig, scaled edge points, box, clamp and the output register.
module lcbb_back import lcbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  entry_t             q_head,
  input  logic               pop,
  output logic               q_rd,
  output logic               empty,
  output logic signed [31:0] lower_x,
  output logic signed [31:0] lower_y,
  output logic signed [31:0] upper_x,
  output logic signed [31:0] upper_y,
  output logic [30:0]        half_width,
  output logic [30:0]        half_height,
  output logic signed [31:0] middle_x,
  output logic signed [31:0] middle_y,
  output logic               saturated
);

  logic                     en;
  logic                     v0;
  entry_t                   r0;
  logic                     vch [CORE_LAT+BOX_LAT];
  logic [30:0]              rad_d [TRIG_LAT];
  logic signed [31:0]       cx_d  [CORE_LAT];
  logic signed [31:0]       cy_d  [CORE_LAT];
  logic                     sp_d  [CORE_LAT];
  logic [30:0]              rad_e [DIV_LAT];
  logic signed [31:0]       ch, sh, c1, s1, c2, s2;
  logic [30:0]              den;
  logic signed [Q_BITS+1:0] q1x, q1y, q2x, q2y;
  logic signed [35:0]       ecx, ecy, p1x, p1y, p2x, p2y;
  logic signed [35:0]       lx, ly, ux, uy;
  logic signed [31:0]       clx, cly, cux, cuy;
  logic                     csat;
  logic signed [32:0]       dx, dy, sx, sy;
  logic signed [35:0]       cxe, cye, rr;
  logic signed [31:0]       bnd_lx, bnd_ly, bnd_ux, bnd_uy;
  logic                     bnd_sat;
  logic signed [31:0]       fin_lx, fin_ly, fin_ux, fin_uy;
  logic                     fin_sat;
  logic [30:0]              fin_hw, fin_hh;
  logic signed [31:0]       fin_mx, fin_my;

  // the whole pipeline moves unless the output register holds an untaken item
  assign en    = !vch[CORE_LAT+BOX_LAT-1] || pop;
  assign q_rd  = en && !q_empty;
  assign empty = !vch[CORE_LAT+BOX_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      for (int k = 0; k < CORE_LAT+BOX_LAT; k++) begin
        vch[k] <= 1'b0;
      end
    end else if (en) begin
      v0     <= !q_empty;
      vch[0] <= v0;
      for (int k = 1; k < CORE_LAT+BOX_LAT; k++) begin
        vch[k] <= vch[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0       <= q_head;
      rad_d[0] <= r0.rad;
      cx_d[0]  <= r0.cx;
      cy_d[0]  <= r0.cy;
      sp_d[0]  <= r0.special;
      for (int k = 1; k < TRIG_LAT; k++) begin
        rad_d[k] <= rad_d[k-1];
      end
      for (int k = 1; k < CORE_LAT; k++) begin
        cx_d[k] <= cx_d[k-1];
        cy_d[k] <= cy_d[k-1];
        sp_d[k] <= sp_d[k-1];
      end
      rad_e[0] <= rad_d[TRIG_LAT-1];
      for (int k = 1; k < DIV_LAT; k++) begin
        rad_e[k] <= rad_e[k-1];
      end
    end
  end

  lcbb_trig u_trig_h (.clk(clk), .en(en), .phase(r0.ph_h), .cs_o(ch), .sn_o(sh));
  lcbb_trig u_trig_1 (.clk(clk), .en(en), .phase(r0.ph_1), .cs_o(c1), .sn_o(s1));
  lcbb_trig u_trig_2 (.clk(clk), .en(en), .phase(r0.ph_2), .cs_o(c2), .sn_o(s2));

  // only the cosine of the half spread is used; its sine is dropped
  assign den = ch[31] ? 31'(-ch) : 31'(ch);

  lcbb_div u_div_1x (.clk(clk), .en(en), .radius(rad_d[TRIG_LAT-1]), .trig(c1),
                     .den(den), .q_o(q1x));
  lcbb_div u_div_1y (.clk(clk), .en(en), .radius(rad_d[TRIG_LAT-1]), .trig(s1),
                     .den(den), .q_o(q1y));
  lcbb_div u_div_2x (.clk(clk), .en(en), .radius(rad_d[TRIG_LAT-1]), .trig(c2),
                     .den(den), .q_o(q2x));
  lcbb_div u_div_2y (.clk(clk), .en(en), .radius(rad_d[TRIG_LAT-1]), .trig(s2),
                     .den(den), .q_o(q2y));

  assign cxe = 36'(cx_d[CORE_LAT-1]);
  assign cye = 36'(cy_d[CORE_LAT-1]);
  assign rr  = signed'(36'(rad_e[DIV_LAT-1]));

  assign clx  = clamp32(lx);
  assign cly  = clamp32(ly);
  assign cux  = clamp32(ux);
  assign cuy  = clamp32(uy);
  assign csat = (lx != 36'(clx)) || (ly != 36'(cly)) ||
                (ux != 36'(cux)) || (uy != 36'(cuy));

  assign dx = 33'(bnd_ux) - 33'(bnd_lx);
  assign dy = 33'(bnd_uy) - 33'(bnd_ly);
  assign sx = 33'(bnd_ux) + 33'(bnd_lx);
  assign sy = 33'(bnd_uy) + 33'(bnd_ly);

  always_ff @(posedge clk) begin
    if (en) begin
      // edge points; a plain box becomes center +/- radius, which min/max keeps
      ecx <= cxe;
      ecy <= cye;
      if (sp_d[CORE_LAT-1]) begin
        p1x <= cxe - rr;
        p2x <= cxe + rr;
        p1y <= cye - rr;
        p2y <= cye + rr;
      end else begin
        p1x <= cxe + 36'(q1x);
        p2x <= cxe + 36'(q2x);
        p1y <= cye + 36'(q1y);
        p2y <= cye + 36'(q2y);
      end
      lx <= min3(ecx, p1x, p2x);
      ux <= max3(ecx, p1x, p2x);
      ly <= min3(ecy, p1y, p2y);
      uy <= max3(ecy, p1y, p2y);
      bnd_lx  <= clx;
      bnd_ly  <= cly;
      bnd_ux  <= cux;
      bnd_uy  <= cuy;
      bnd_sat <= csat;
    end
  end

  // output register: bounds, half sizes and middle of the same item
  always_ff @(posedge clk) begin
    if (en) begin
      fin_lx  <= bnd_lx;
      fin_ly  <= bnd_ly;
      fin_ux  <= bnd_ux;
      fin_uy  <= bnd_uy;
      fin_sat <= bnd_sat;
      fin_hw  <= dx[31:1];
      fin_hh  <= dy[31:1];
      fin_mx  <= sx[32:1];
      fin_my  <= sy[32:1];
    end
  end

  assign lower_x     = fin_lx;
  assign lower_y     = fin_ly;
  assign upper_x     = fin_ux;
  assign upper_y     = fin_uy;
  assign saturated   = fin_sat;
  assign half_width  = fin_hw;
  assign half_height = fin_hh;
  assign middle_x    = fin_mx;
  assign middle_y    = fin_my;

endmodule

### design/light_cone_bounding_box.sv
// Top level of the light cone bounding box.
//
// Input channel: push/full. An item (one light: center, radius, direction,
// spread) is taken at a rising edge with push high and full low. It lands
// in a four-entry queue, so the source can keep pushing while the compute
// pipeline is held.
// Result channel: empty/pop. While empty is low the oldest box is on the
// result ports; it is taken at a rising edge with pop high.
// Throughput: one item per cycle while the result side is not stalled,
// set by the fully pipelined sine/cosine units (three per item) and four
// one-bit-per-stage dividers.
// Path to empty going low: queue and input register, 19 trig stages,
// 36 divider stages, and four box, clamp and output stages.
// Stall: when the result register holds an item that is not popped, the
// whole pipeline freezes; the queue then absorbs up to four items before
// full rises.
// Reset (rst, synchronous): queue and all stage valid bits clear; empty
// goes high and full low on the next cycle.
module light_cone_bounding_box import lcbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        light_radius,
  input  logic [15:0]        direction_angle,
  input  logic [16:0]        spread_angle,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] lower_x,
  output logic signed [31:0] lower_y,
  output logic signed [31:0] upper_x,
  output logic signed [31:0] upper_y,
  output logic [30:0]        half_width,
  output logic [30:0]        half_height,
  output logic signed [31:0] middle_x,
  output logic signed [31:0] middle_y,
  output logic               saturated
);

  logic   wr;
  entry_t ent;
  entry_t head;
  logic   q_empty;
  logic   q_rd;

  // classify the item and turn angles into 32-bit phases
  lcbb_front u_front (
    .push           (push),
    .full           (full),
    .center_x       (center_x),
    .center_y       (center_y),
    .light_radius   (light_radius),
    .direction_angle(direction_angle),
    .spread_angle   (spread_angle),
    .wr             (wr),
    .ent            (ent)
  );

  // decouples accepting items from a stalled pipeline
  lcbb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .wr_ent(ent),
    .rd    (q_rd),
    .head  (head),
    .full  (full),
    .empty (q_empty)
  );

  // trig, scale, box; its last stage is the result register
  lcbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (head),
    .pop        (pop),
    .q_rd       (q_rd),
    .empty      (empty),
    .lower_x    (lower_x),
    .lower_y    (lower_y),
    .upper_x    (upper_x),
    .upper_y    (upper_y),
    .half_width (half_width),
    .half_height(half_height),
    .middle_x   (middle_x),
    .middle_y   (middle_y),
    .saturated  (saturated)
  );

endmodule

### design/lcbb_checker.sv
// Port-level checks of the light cone bounding box, bound to the top level.
module lcbb_checker import lcbb_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] lower_x,
  input logic signed [31:0] lower_y,
  input logic signed [31:0] upper_x,
  input logic signed [31:0] upper_y,
  input logic [30:0]        half_width,
  input logic [30:0]        half_height,
  input logic signed [31:0] middle_x,
  input logic signed [31:0] middle_y,
  input logic               saturated
);

  logic signed [32:0] dx;
  logic signed [32:0] sx;
  logic signed [32:0] dy;
  logic signed [32:0] sy;

  assign dx = 33'(upper_x) - 33'(lower_x);
  assign sx = 33'(upper_x) + 33'(lower_x);
  assign dy = 33'(upper_y) - 33'(lower_y);
  assign sy = 33'(upper_y) + 33'(lower_y);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue or result not cleared by reset");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (upper_x >= lower_x) && (upper_y >= lower_y))
    else $error("box bounds out of order");

  a_box_derived: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (half_width == dx[31:1]) && (middle_x == sx[32:1]) &&
               (half_height == dy[31:1]) && (middle_y == sy[32:1]))
    else $error("half size or middle does not match the bounds");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(lower_x) && $stable(saturated))
    else $error("waiting result changed");

endmodule

bind light_cone_bounding_box lcbb_checker u_lcbb_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .lower_x    (lower_x),
  .lower_y    (lower_y),
  .upper_x    (upper_x),
  .upper_y    (upper_y),
  .half_width (half_width),
  .half_height(half_height),
  .middle_x   (middle_x),
  .middle_y   (middle_y),
  .saturated  (saturated)
);
